>>> rtl/cdas_pkg.sv
// ----------------------------------------------------------------------------
// cdas_pkg
// Shared types for the calendar date counter: item kinds, result status codes
// and the command and status groups between the controller and the datapath.
// ----------------------------------------------------------------------------
package cdas_pkg;

    // item kinds, code 3 is unused and handled as a no-op
    typedef enum logic [1:0] {
        KIND_LOAD    = 2'd0,
        KIND_ADVANCE = 2'd1,
        KIND_MEASURE = 2'd2
    } kind_t;

    // result status codes
    localparam logic [1:0] ST_OK   = 2'd0;
    localparam logic [1:0] ST_OVF  = 2'd1;
    localparam logic [1:0] ST_MISS = 2'd2;

    // controller to datapath
    typedef struct packed {
        logic capture;    // take the input beat into the working registers
        logic load;       // store the clamped load date
        logic adv_step;   // one month step of an advance
        logic meas_step;  // one month step of a measure
        logic publish;    // move the result into the output register
    } cmd_t;

    // datapath to controller
    typedef struct packed {
        kind_t kind;      // kind of the item being worked on
        logic  adv_done;  // the current advance step is the last one
        logic  meas_done; // the current measure step is the last one
        logic  slot_free; // output register can take a result this cycle
    } sts_t;

endpackage

>>> rtl/calendar_date_advance_and_span.sv
// ----------------------------------------------------------------------------
// calendar_date_advance_and_span
// Gregorian date counter: load a date, advance it by a day count, or measure
// the days from the stored date to a target date.
// ----------------------------------------------------------------------------
// One item is handled at a time. A load or an unused kind passes through the
// capture, run and finish states before the next beat is accepted; an advance
// steps through each month boundary it crosses, and a measure through each
// month the walker passes before reaching the target or the span limit. The
// month step loop in the datapath moves the date or the walker by one month
// per cycle. The result sits in an output register, so the next beat is taken
// while the previous result is still waiting; only a finished item waits on
// a stalled result.
module calendar_date_advance_and_span
    import cdas_pkg::*;
#(
    parameter int MAX_SPAN = 65535
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        item_valid,
    output logic        item_stall,
    input  logic [1:0]  kind,
    input  logic [4:0]  day_in,
    input  logic [3:0]  month_in,
    input  logic [13:0] year_in,
    input  logic [15:0] count_in,
    output logic        result_valid,
    input  logic        result_stall,
    output logic [4:0]  day_out,
    output logic [3:0]  month_out,
    output logic [13:0] year_out,
    output logic [15:0] span_days,
    output logic [1:0]  status
);

    cmd_t cmd;
    sts_t sts;

    // sequencer
    cdas_ctrl u_ctrl (
        .clk        (clk),
        .rst_n      (rst_n),
        .item_valid (item_valid),
        .item_stall (item_stall),
        .sts        (sts),
        .cmd        (cmd)
    );

    // date registers, month stepper and output register
    cdas_dp #(
        .MAX_SPAN (MAX_SPAN)
    ) u_dp (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd          (cmd),
        .sts          (sts),
        .kind         (kind),
        .day_in       (day_in),
        .month_in     (month_in),
        .year_in      (year_in),
        .count_in     (count_in),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .day_out      (day_out),
        .month_out    (month_out),
        .year_out     (year_out),
        .span_days    (span_days),
        .status       (status)
    );

endmodule

>>> rtl/cdas_ctrl.sv
// ----------------------------------------------------------------------------
// cdas_ctrl
// Sequencer of the date counter: takes one beat, runs the datapath month by
// month until the item is finished, then hands the result to the output
// register.
// ----------------------------------------------------------------------------
module cdas_ctrl
    import cdas_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic item_valid,
    output logic item_stall,
    input  sts_t sts,
    output cmd_t cmd
);

    typedef enum logic [1:0] {
        S_IDLE,
        S_RUN,
        S_FIN
    } state_t;

    state_t state_reg;
    state_t state_next;
    logic   stall_reg;

    // next state and commands
    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        unique case (state_reg)
            S_IDLE:
            begin
                if (item_valid)
                begin
                    cmd.capture = 1'b1;
                    state_next  = S_RUN;
                end
            end
            S_RUN:
            begin
                case (sts.kind)
                    KIND_LOAD:
                    begin
                        cmd.load   = 1'b1;
                        state_next = S_FIN;
                    end
                    KIND_ADVANCE:
                    begin
                        cmd.adv_step = 1'b1;
                        if (sts.adv_done)
                        begin
                            state_next = S_FIN;
                        end
                    end
                    KIND_MEASURE:
                    begin
                        cmd.meas_step = 1'b1;
                        if (sts.meas_done)
                        begin
                            state_next = S_FIN;
                        end
                    end
                    default:
                    begin
                        state_next = S_FIN;
                    end
                endcase
            end
            S_FIN:
            begin
                if (sts.slot_free)
                begin
                    cmd.publish = 1'b1;
                    state_next  = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // state and registered stall
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            stall_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            stall_reg <= (state_next != S_IDLE);
        end
    end

    assign item_stall = stall_reg;

endmodule

>>> rtl/cdas_dp.sv
// ----------------------------------------------------------------------------
// cdas_dp
// Datapath of the date counter: stored date, captured item, month walker for
// measure, day counter for advance, and the output register.
// ----------------------------------------------------------------------------
module cdas_dp
    import cdas_pkg::*;
#(
    parameter int MAX_SPAN = 65535
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  cmd_t        cmd,
    output sts_t        sts,
    input  logic [1:0]  kind,
    input  logic [4:0]  day_in,
    input  logic [3:0]  month_in,
    input  logic [13:0] year_in,
    input  logic [15:0] count_in,
    output logic        result_valid,
    input  logic        result_stall,
    output logic [4:0]  day_out,
    output logic [3:0]  month_out,
    output logic [13:0] year_out,
    output logic [15:0] span_days,
    output logic [1:0]  status
);

    // span limit is also capped by the width of the span field
    localparam int SPAN_LIM = (MAX_SPAN > 65535) ? 65535 : MAX_SPAN;
    localparam int ACC_W    = $clog2(SPAN_LIM + 32);

    localparam logic [ACC_W-1:0] LIM_V     = ACC_W'(SPAN_LIM);
    localparam logic [13:0]      YEAR_MAX  = 14'd9999;
    localparam logic [13:0]      YEAR_RST  = 14'd2000;
    localparam logic [3:0]       MONTH_MAX = 4'd12;
    localparam logic [4:0]       DAY_LAST  = 5'd31;
    localparam logic [13:0]      INV25     = 14'd7209;   // 25 * 7209 = 1 mod 2^14
    localparam logic [13:0]      DIV25_MAX = 14'd655;    // largest quotient of 25 below 2^14

    // leap rule; multiple of 25 tested through the inverse of 25 mod 2^14
    function automatic logic is_leap(input logic [13:0] y);
        logic [13:0] p;
        logic        div25;
        p     = y * INV25;
        div25 = (p <= DIV25_MAX);
        return (y[1:0] == 2'b00) && (!div25 || (y[3:0] == 4'b0000));
    endfunction

    function automatic logic [4:0] month_len(input logic [3:0] m, input logic leap);
        logic [4:0] n;
        case (m) inside
            4'd2:                   n = leap ? 5'd29 : 5'd28;
            4'd4, 4'd6, 4'd9, 4'd11: n = 5'd30;
            default:                n = 5'd31;
        endcase
        return n;
    endfunction

    // stored date
    logic [4:0]  cur_d_reg, cur_d_next;
    logic [3:0]  cur_m_reg, cur_m_next;
    logic [13:0] cur_y_reg, cur_y_next;

    // captured item
    kind_t       kind_reg;
    logic [4:0]  d_reg;
    logic [3:0]  m_reg;
    logic [13:0] y_reg;
    logic [15:0] cnt_reg, cnt_next;

    // measure walker
    logic [4:0]       wd_reg, wd_next;
    logic [3:0]       wm_reg, wm_next;
    logic [13:0]      wy_reg, wy_next;
    logic [ACC_W-1:0] acc_reg, acc_next;

    // result under construction
    logic [15:0] span_reg, span_next;
    logic [1:0]  st_reg, st_next;

    // output register
    logic        result_valid_reg;
    logic [4:0]  day_out_reg;
    logic [3:0]  month_out_reg;
    logic [13:0] year_out_reg;
    logic [15:0] span_out_reg;
    logic [1:0]  status_out_reg;

    // load clamping
    logic [3:0]  ld_m;
    logic [13:0] ld_y;
    logic [4:0]  ld_ml;
    logic [4:0]  ld_d;

    always_comb
    begin
        ld_m  = (m_reg == 4'd0) ? 4'd1 : ((m_reg > MONTH_MAX) ? MONTH_MAX : m_reg);
        ld_y  = (y_reg == 14'd0) ? 14'd1 : ((y_reg > YEAR_MAX) ? YEAR_MAX : y_reg);
        ld_ml = month_len(ld_m, is_leap(ld_y));
        ld_d  = (d_reg == 5'd0) ? 5'd1 : ((d_reg > ld_ml) ? ld_ml : d_reg);
    end

    // advance: one month per step
    logic [4:0] cur_ml;
    logic [4:0] left;
    logic       cnt_zero;
    logic       cnt_gt;
    logic       at_end;

    always_comb
    begin
        cur_ml   = month_len(cur_m_reg, is_leap(cur_y_reg));
        left     = cur_ml - cur_d_reg;
        cnt_zero = (cnt_reg == 16'd0);
        cnt_gt   = (cnt_reg > {11'd0, left});
        at_end   = (cur_m_reg == MONTH_MAX) && (cur_y_reg == YEAR_MAX);
    end

    // measure: one month per step of the walker
    logic             t_ok;
    logic             w_same;
    logic             w_past;
    logic [4:0]       w_ml;
    logic [ACC_W-1:0] diff;
    logic [ACC_W-1:0] nacc;
    logic             meas_done;
    logic             meas_fail;
    logic             meas_walk;

    always_comb
    begin
        t_ok   = (m_reg != 4'd0) && (m_reg <= MONTH_MAX) && (y_reg != 14'd0) &&
                 (d_reg != 5'd0) && (d_reg <= month_len(m_reg, is_leap(y_reg)));
        w_same = (wy_reg == y_reg) && (wm_reg == m_reg);
        w_past = (wy_reg > y_reg) || ((wy_reg == y_reg) && (wm_reg > m_reg));
        w_ml   = month_len(wm_reg, is_leap(wy_reg));
        diff   = acc_reg + ACC_W'(d_reg) - ACC_W'(wd_reg);
        nacc   = acc_reg + ACC_W'(w_ml) - ACC_W'(wd_reg) + ACC_W'(1);

        meas_done = 1'b1;
        meas_fail = 1'b0;
        meas_walk = 1'b0;
        if (!t_ok)
        begin
            meas_fail = 1'b1;
        end
        else if (w_same)
        begin
            meas_fail = (d_reg < wd_reg) || (diff > LIM_V);
        end
        else if (w_past || (nacc > LIM_V))
        begin
            meas_fail = 1'b1;
        end
        else
        begin
            meas_done = 1'b0;
            meas_walk = 1'b1;
        end
    end

    // next values of the working registers
    always_comb
    begin
        cur_d_next = cur_d_reg;
        cur_m_next = cur_m_reg;
        cur_y_next = cur_y_reg;
        cnt_next   = cnt_reg;
        wd_next    = wd_reg;
        wm_next    = wm_reg;
        wy_next    = wy_reg;
        acc_next   = acc_reg;
        span_next  = span_reg;
        st_next    = st_reg;

        if (cmd.capture)
        begin
            cnt_next  = count_in;
            wd_next   = cur_d_reg;
            wm_next   = cur_m_reg;
            wy_next   = cur_y_reg;
            acc_next  = '0;
            span_next = 16'd0;
            st_next   = ST_OK;
        end
        else if (cmd.load)
        begin
            cur_d_next = ld_d;
            cur_m_next = ld_m;
            cur_y_next = ld_y;
        end
        else if (cmd.adv_step && !cnt_zero)
        begin
            if (cnt_gt)
            begin
                cnt_next   = cnt_reg - {11'd0, left} - 16'd1;
                cur_d_next = 5'd1;
                if (at_end)
                begin
                    cur_d_next = DAY_LAST;
                    cnt_next   = 16'd0;
                    st_next    = ST_OVF;
                end
                else if (cur_m_reg == MONTH_MAX)
                begin
                    cur_m_next = 4'd1;
                    cur_y_next = cur_y_reg + 14'd1;
                end
                else
                begin
                    cur_m_next = cur_m_reg + 4'd1;
                end
            end
            else
            begin
                cur_d_next = cur_d_reg + cnt_reg[4:0];
                cnt_next   = 16'd0;
            end
        end
        else if (cmd.meas_step)
        begin
            if (meas_walk)
            begin
                acc_next = nacc;
                wd_next  = 5'd1;
                if (wm_reg == MONTH_MAX)
                begin
                    wm_next = 4'd1;
                    wy_next = wy_reg + 14'd1;
                end
                else
                begin
                    wm_next = wm_reg + 4'd1;
                end
            end
            else if (meas_fail)
            begin
                st_next   = ST_MISS;
                span_next = 16'd0;
            end
            else
            begin
                span_next = 16'(diff);
            end
        end
    end

    // stored date
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cur_d_reg <= 5'd1;
            cur_m_reg <= 4'd1;
            cur_y_reg <= YEAR_RST;
        end
        else
        begin
            cur_d_reg <= cur_d_next;
            cur_m_reg <= cur_m_next;
            cur_y_reg <= cur_y_next;
        end
    end

    // captured item, walker and result fields
    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            kind_reg <= kind_t'(kind);
            d_reg    <= day_in;
            m_reg    <= month_in;
            y_reg    <= year_in;
        end
        cnt_reg  <= cnt_next;
        wd_reg   <= wd_next;
        wm_reg   <= wm_next;
        wy_reg   <= wy_next;
        acc_reg  <= acc_next;
        span_reg <= span_next;
        st_reg   <= st_next;
    end

    // output register: valid flag
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            result_valid_reg <= 1'b0;
        end
        else
        begin
            result_valid_reg <= cmd.publish || (result_valid_reg && result_stall);
        end
    end

    // output register: payload
    always_ff @(posedge clk)
    begin
        if (cmd.publish)
        begin
            day_out_reg    <= cur_d_reg;
            month_out_reg  <= cur_m_reg;
            year_out_reg   <= cur_y_reg;
            span_out_reg   <= span_reg;
            status_out_reg <= st_reg;
        end
    end

    // status toward the controller
    always_comb
    begin
        sts.kind      = kind_reg;
        sts.adv_done  = cnt_zero || !cnt_gt || at_end;
        sts.meas_done = meas_done;
        sts.slot_free = !result_valid_reg || !result_stall;
    end

    assign result_valid = result_valid_reg;
    assign day_out      = day_out_reg;
    assign month_out    = month_out_reg;
    assign year_out     = year_out_reg;
    assign span_days    = span_out_reg;
    assign status       = status_out_reg;

    // stored date is always a real calendar date in range
    a_cur_date_valid: assert property (@(posedge clk) disable iff (!rst_n)
        (cur_m_reg >= 4'd1) && (cur_m_reg <= MONTH_MAX) && (cur_d_reg >= 5'd1) &&
        (cur_d_reg <= cur_ml) && (cur_y_reg >= 14'd1) && (cur_y_reg <= YEAR_MAX))
        else $error("stored date out of range");

    // a failed or saturated result never carries a span
    a_span_zero_on_error: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && (status != ST_OK) |-> (span_days == 16'd0))
        else $error("nonzero span with error status");

    // overflow pins the date to the last day of the calendar
    a_overflow_date: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && (status == ST_OVF) |->
        (day_out == DAY_LAST) && (month_out == MONTH_MAX) && (year_out == YEAR_MAX))
        else $error("overflow result not saturated");

    // a new result never overwrites one that is still held
    a_publish_free: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.publish |-> (!result_valid_reg || !result_stall))
        else $error("result overwritten while stalled");

endmodule

>>> tb/calendar_checker.sv
// ----------------------------------------------------------------------------
// calendar_checker
// Watches both channels of the date counter, works out the date, span and
// status each accepted item should produce, and compares every result beat
// against the oldest prediction still waiting.
// ----------------------------------------------------------------------------
module calendar_checker
    import cdas_pkg::*;
#(
    parameter int MAX_SPAN = 65535
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        item_valid,
    input  logic        item_stall,
    input  logic [1:0]  kind,
    input  logic [4:0]  day_in,
    input  logic [3:0]  month_in,
    input  logic [13:0] year_in,
    input  logic [15:0] count_in,
    input  logic        result_valid,
    input  logic        result_stall,
    input  logic [4:0]  day_out,
    input  logic [3:0]  month_out,
    input  logic [13:0] year_out,
    input  logic [15:0] span_days,
    input  logic [1:0]  status,
    output int          waiting,
    output int          mismatch_count
);
    timeunit 1ns;
    timeprecision 1ps;

    // the span field is 16 bits, so a wider limit still stops there
    localparam longint SPAN_LIMIT = (MAX_SPAN > 65535) ? 65535 : MAX_SPAN;

    typedef struct {
        logic [4:0]  day;
        logic [3:0]  month;
        logic [13:0] year;
        logic [15:0] span;
        logic [1:0]  status;
    } date_result_t;

    date_result_t expected_dates[$];

    // predicted stored date
    int unsigned cal_day   = 1;
    int unsigned cal_month = 1;
    int unsigned cal_year  = 2000;

    function automatic bit leap_year(input int unsigned y);
        return (y % 4 == 0) && ((y % 100 != 0) || (y % 400 == 0));
    endfunction

    function automatic int unsigned days_in_month(input int unsigned m, input int unsigned y);
        case (m) inside
            2:           return leap_year(y) ? 29 : 28;
            4, 6, 9, 11: return 30;
            default:     return 31;
        endcase
    endfunction

    // running day count with 0001-01-01 as day 1
    function automatic longint day_number(input int unsigned d, input int unsigned m,
                                          input int unsigned y);
        longint p;
        longint n;
        p = longint'(y) - 1;
        n = 365 * p + p / 4 - p / 100 + p / 400;
        for (int unsigned k = 1; k < m; k++)
            n += days_in_month(k, y);
        return n + d;
    endfunction

    // updates the predicted date and returns the result beat for one item
    function automatic date_result_t apply_item(input logic [1:0] k, input logic [4:0] d,
                                                input logic [3:0] m, input logic [13:0] y,
                                                input logic [15:0] cnt);
        date_result_t r;
        int unsigned  dd;
        int unsigned  mm;
        int unsigned  yy;
        int unsigned  rem;
        int unsigned  left;
        longint       gap;
        dd = d;
        mm = m;
        yy = y;
        r.span = '0;
        r.status = ST_OK;
        case (kind_t'(k))
            KIND_LOAD:
            begin
                // clamp each field into a real date
                if (mm < 1) mm = 1;
                if (mm > 12) mm = 12;
                if (yy < 1) yy = 1;
                if (yy > 9999) yy = 9999;
                if (dd < 1) dd = 1;
                if (dd > days_in_month(mm, yy)) dd = days_in_month(mm, yy);
                cal_day = dd;
                cal_month = mm;
                cal_year = yy;
            end
            KIND_ADVANCE:
            begin
                // jump a month at a time, then finish inside the month
                rem = cnt;
                while (rem > 0) begin
                    left = days_in_month(cal_month, cal_year) - cal_day;
                    if (rem > left) begin
                        rem -= left + 1;
                        cal_day = 1;
                        cal_month++;
                        if (cal_month > 12) begin
                            cal_month = 1;
                            cal_year++;
                            if (cal_year > 9999) begin
                                cal_day = 31;
                                cal_month = 12;
                                cal_year = 9999;
                                r.status = ST_OVF;
                                rem = 0;
                            end
                        end
                    end
                    else begin
                        cal_day += rem;
                        rem = 0;
                    end
                end
            end
            KIND_MEASURE:
            begin
                // target must be a real date, not behind and not too far ahead
                if (mm >= 1 && mm <= 12 && yy >= 1 && dd >= 1 && dd <= days_in_month(mm, yy))
                begin
                    gap = day_number(dd, mm, yy) - day_number(cal_day, cal_month, cal_year);
                    if (gap >= 0 && gap <= SPAN_LIMIT)
                        r.span = gap[15:0];
                    else
                        r.status = ST_MISS;
                end
                else begin
                    r.status = ST_MISS;
                end
            end
            default:
            begin
                // unused kind leaves everything as it is
            end
        endcase
        r.day = cal_day[4:0];
        r.month = cal_month[3:0];
        r.year = cal_year[13:0];
        return r;
    endfunction

    task automatic report_mismatch(input string what, input int got, input int want);
        $display("%0t ns: %s mismatch, got %0d expected %0d", $time, what, got, want);
        mismatch_count++;
    endtask

    // compare result beats, then predict for item beats
    always @(posedge clk or negedge rst_n) begin : watch
        date_result_t want;
        if (!rst_n) begin
            expected_dates.delete();
            cal_day = 1;
            cal_month = 1;
            cal_year = 2000;
            mismatch_count = 0;
            waiting <= 0;
        end
        else begin
            if (result_valid && !result_stall) begin
                if (expected_dates.size() == 0) begin
                    report_mismatch("result beat with nothing pending", 1, 0);
                end
                else begin
                    want = expected_dates.pop_front();
                    if (day_out !== want.day)
                        report_mismatch("day_out", day_out, want.day);
                    if (month_out !== want.month)
                        report_mismatch("month_out", month_out, want.month);
                    if (year_out !== want.year)
                        report_mismatch("year_out", year_out, want.year);
                    if (span_days !== want.span)
                        report_mismatch("span_days", span_days, want.span);
                    if (status !== want.status)
                        report_mismatch("status", status, want.status);
                end
            end
            if (item_valid && !item_stall)
                expected_dates.push_back(apply_item(kind, day_in, month_in, year_in, count_in));
            waiting <= expected_dates.size();
        end
    end

endmodule

>>> tb/tb_calendar_date_advance_and_span.sv
// ----------------------------------------------------------------------------
// tb_calendar_date_advance_and_span
// Drives loads, advances and measures into the date counter with bursty
// input and a stalling receiver, and gives the verdict from the checker.
// ----------------------------------------------------------------------------
module tb_calendar_date_advance_and_span
    import cdas_pkg::*;
();

    timeunit 1ns;
    timeprecision 1ps;

    localparam int         SPAN_MAX    = 65535;
    localparam int         ITEM_TARGET = 270;
    localparam logic [1:0] KIND_UNUSED = 2'd3;

    logic        clk;
    logic        rst_n;
    logic        item_valid;
    logic        item_stall;
    logic [1:0]  kind;
    logic [4:0]  day_in;
    logic [3:0]  month_in;
    logic [13:0] year_in;
    logic [15:0] count_in;
    logic        result_valid;
    logic        result_stall;
    logic [4:0]  day_out;
    logic [3:0]  month_out;
    logic [13:0] year_out;
    logic [15:0] span_days;
    logic [1:0]  status;

    int waiting;
    int mismatch_count;
    int items_sent = 0;
    int burst_left = 0;
    bit hold_req   = 1'b0;

    calendar_date_advance_and_span #(.MAX_SPAN(SPAN_MAX)) dut (.*);

    calendar_checker #(.MAX_SPAN(SPAN_MAX)) date_checker (.*);

    // clock
    initial begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // give up after far longer than the slowest correct run
    initial begin
        #40_000_000;
        $display("calendar_date_advance_and_span test failed");
        $finish;
    end

    // receiver: stall patterns in stretches, plus one long hold-off on request
    initial begin : receiver
        int mode;
        int left;
        int hold;
        result_stall <= 1'b0;
        @(posedge rst_n);
        forever begin
            mode = $urandom_range(0, 2);
            left = $urandom_range(20, 150);
            while (left > 0 && !hold_req) begin
                @(posedge clk);
                case (mode)
                    0:       result_stall <= 1'b0;
                    1:       result_stall <= ($urandom_range(0, 3) == 0);
                    default: result_stall <= ($urandom_range(0, 3) != 0);
                endcase
                left--;
            end
            if (hold_req) begin
                hold = 400;
                while (hold > 0) begin
                    @(posedge clk);
                    result_stall <= 1'b1;
                    hold--;
                end
                hold_req = 1'b0;
            end
        end
    end

    // offer one item beat and wait for it to be taken, then maybe idle
    task automatic send_item(input logic [1:0] k, input logic [4:0] d, input logic [3:0] m,
                             input logic [13:0] y, input logic [15:0] c);
        int gap;
        item_valid <= 1'b1;
        kind <= k;
        day_in <= d;
        month_in <= m;
        year_in <= y;
        count_in <= c;
        do @(posedge clk); while (item_stall);
        items_sent++;
        if (burst_left > 0) begin
            burst_left--;
        end
        else begin
            gap = $urandom_range(1, 12);
            item_valid <= 1'b0;
            kind <= 2'($urandom);
            day_in <= 5'($urandom);
            month_in <= 4'($urandom);
            year_in <= 14'($urandom);
            count_in <= 16'($urandom);
            repeat (gap) @(posedge clk);
            burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(30, 60)
                                                     : $urandom_range(0, 15);
        end
    endtask

    // stop offering until every predicted result has come back
    task automatic wait_drained();
        item_valid <= 1'b0;
        @(posedge clk);
        while (waiting != 0) @(posedge clk);
    endtask

    // load a date, then advance it and measure towards dates near it
    task automatic run_date_sequence();
        logic [4:0]  bd;
        logic [3:0]  bm;
        logic [13:0] by;
        int          ops;
        case ($urandom_range(0, 3))
            0:       by = 14'($urandom_range(1, 20));
            1:       by = 14'($urandom_range(9900, 9999));
            default: by = 14'($urandom_range(1, 9999));
        endcase
        bm = 4'($urandom_range(1, 12));
        bd = ($urandom_range(0, 4) == 0) ? 5'($urandom_range(1, 31))
                                         : 5'($urandom_range(1, 28));
        send_item(KIND_LOAD, bd, bm, by, 16'($urandom));
        ops = $urandom_range(1, 4);
        repeat (ops) begin
            case ($urandom_range(0, 2))
                0:       send_item(KIND_ADVANCE, 5'($urandom), 4'($urandom), 14'($urandom),
                                   ($urandom_range(0, 9) == 0) ? 16'($urandom_range(0, 65535))
                                                               : 16'($urandom_range(0, 1500)));
                1:       send_item(KIND_MEASURE, 5'($urandom_range(1, 28)),
                                   4'($urandom_range(1, 12)),
                                   14'(by + $urandom_range(0, 179)), 16'($urandom));
                default: send_item(KIND_MEASURE, bd, bm, by, 16'($urandom));
            endcase
        end
    endtask

    // stimulus and verdict
    initial begin : stimulus
        bit hold_done;
        bit pause_done;
        hold_done = 1'b0;
        pause_done = 1'b0;
        rst_n <= 1'b0;
        item_valid <= 1'b0;
        kind <= KIND_LOAD;
        day_in <= '0;
        month_in <= '0;
        year_in <= '0;
        count_in <= '0;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: reset date, clamping, leap rules, saturation, span edges
        send_item(KIND_MEASURE, 5'd1, 4'd1, 14'd2000, 16'd0);
        send_item(KIND_ADVANCE, 5'd0, 4'd0, 14'd0, 16'd0);
        send_item(KIND_LOAD, 5'd0, 4'd0, 14'd0, 16'd0);
        send_item(KIND_ADVANCE, 5'd0, 4'd0, 14'd0, 16'hFFFF);
        send_item(KIND_LOAD, 5'd31, 4'd2, 14'd2000, 16'd0);
        send_item(KIND_LOAD, 5'd29, 4'd2, 14'd1900, 16'd0);
        send_item(KIND_LOAD, 5'd31, 4'd4, 14'd2023, 16'd0);
        send_item(KIND_LOAD, 5'd31, 4'd15, 14'd16383, 16'd0);
        send_item(KIND_ADVANCE, 5'd31, 4'd15, 14'd16383, 16'd1);
        send_item(KIND_LOAD, 5'd30, 4'd12, 14'd9999, 16'd0);
        send_item(KIND_ADVANCE, 5'd0, 4'd0, 14'd0, 16'd1);
        send_item(KIND_ADVANCE, 5'd0, 4'd0, 14'd0, 16'hFFFF);
        send_item(KIND_MEASURE, 5'd1, 4'd1, 14'd10000, 16'd0);
        send_item(KIND_MEASURE, 5'd1, 4'd1, 14'd16383, 16'd0);
        send_item(KIND_LOAD, 5'd1, 4'd1, 14'd2000, 16'd0);
        // 2179-06-06 lies exactly at the span limit from 2000-01-01
        send_item(KIND_MEASURE, 5'd6, 4'd6, 14'd2179, 16'd0);
        send_item(KIND_MEASURE, 5'd7, 4'd6, 14'd2179, 16'd0);
        send_item(KIND_ADVANCE, 5'd0, 4'd0, 14'd0, 16'hFFFF);
        // targets that are not real dates, or already behind
        send_item(KIND_MEASURE, 5'd0, 4'd6, 14'd2179, 16'd0);
        send_item(KIND_MEASURE, 5'd31, 4'd6, 14'd2179, 16'd0);
        send_item(KIND_MEASURE, 5'd1, 4'd0, 14'd2180, 16'd0);
        send_item(KIND_MEASURE, 5'd1, 4'd13, 14'd2180, 16'd0);
        send_item(KIND_MEASURE, 5'd1, 4'd1, 14'd0, 16'd0);
        send_item(KIND_MEASURE, 5'd5, 4'd6, 14'd2179, 16'd0);
        send_item(KIND_UNUSED, 5'd31, 4'd15, 14'd16383, 16'hFFFF);
        wait_drained();

        // random: mostly date sequences, some raw noise
        while (items_sent < ITEM_TARGET) begin
            if (!hold_done && items_sent >= 100) begin
                // receiver holds off while loads keep coming
                hold_req = 1'b1;
                burst_left = 30;
                repeat (12)
                    send_item(KIND_LOAD, 5'($urandom_range(1, 28)), 4'($urandom_range(1, 12)),
                              14'($urandom_range(1, 9999)), 16'($urandom));
                hold_done = 1'b1;
            end
            if (!pause_done && items_sent >= 180) begin
                wait_drained();
                pause_done = 1'b1;
            end
            if ($urandom_range(0, 9) < 7)
                run_date_sequence();
            else
                send_item(2'($urandom_range(0, 3)), 5'($urandom), 4'($urandom),
                          14'($urandom), 16'($urandom));
        end

        wait_drained();
        repeat (20) @(posedge clk);
        if (mismatch_count == 0 && waiting == 0)
            $display("calendar_date_advance_and_span test passed");
        else
            $display("calendar_date_advance_and_span test failed");
        $finish;
    end

endmodule
